>>> rtl/semver_string_parser_top_macros.svh
// Assertion macros used by the semantic version parser RTL.
`ifndef SEMVER_STRING_PARSER_TOP_MACROS_SVH
`define SEMVER_STRING_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ssp_pkg.sv
// Shared constants and types for the semantic version string parser.
package ssp_pkg;

	localparam int MAX_LENGTH_DEF   = 256;
	localparam int NUMBER_WIDTH_DEF = 32;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;

	// Bit positions in the identifier flags.
	localparam int PF_EMPTY    = 0;
	localparam int PF_ZERO     = 1;
	localparam int PF_MULTI    = 2;
	localparam int PF_NONDIGIT = 3;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_CORE  = 3'd1,
		ERR_DOT   = 3'd2,
		ERR_PRE   = 3'd3,
		ERR_BUILD = 3'd4,
		ERR_SIZE  = 3'd5
	} error_kind_t;

	typedef struct packed {
		logic [7:0]  build_len;
		logic [7:0]  build_offset;
		logic        has_build;
		logic [7:0]  pre_rel_len;
		logic [7:0]  pre_release_offset;
		logic        has_pre_release;
		logic [31:0] patch_value;
		logic [31:0] minor_value;
		logic [31:0] major_value;
		error_kind_t error_kind;
		logic        valid_res;
	} result_t;

endpackage

>>> rtl/semver_string_parser_top.sv
// Streaming semantic version 2.0 string parser, one character per request.
//
//  Channel | Signals                          | Contents
//  --------+----------------------------------+----------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tlast | one character, tlast on the final one
//  output  | m_tvalid m_tready m_tdata         | one parse result per string
//
// The parser takes one character every cycle while input is not stalled. Each character
// is first held in an input register; from there the character check and the
// multiply-by-ten accumulate update the parser state, and on the final character the
// result register is loaded and a result is offered as its last character moves on.
// Reset clears the parser to the start of a new string, with no result pending.
// Input stalls only while a final character waits in the input register and the
// previous result has not yet been taken; other characters flow past a waiting result.
`include "semver_string_parser_top_macros.svh"

module semver_string_parser_top #(
	parameter int MAX_LENGTH   = ssp_pkg::MAX_LENGTH_DEF,
	parameter int NUMBER_WIDTH = ssp_pkg::NUMBER_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] character
	input  logic         s_tlast,   // marks the final character of the string
	output logic         m_tvalid,
	input  logic         m_tready,
	// From bit 0 up: valid_res, error_kind[2:0], major_value[31:0], minor_value[31:0],
	// patch_value[31:0], has_pre_release, pre_release_offset[7:0],
	// pre_rel_len[7:0], has_build, build_offset[7:0], build_len[7:0],
	// two zero bits of padding.
	output logic [135:0] m_tdata
);

	// The position counter saturates one past the length limit.
	localparam int PW = $clog2(MAX_LENGTH + 2);
	localparam int NW = NUMBER_WIDTH;
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_LENGTH);

	typedef enum logic [2:0] {
		PH_MAJOR,
		PH_MINOR,
		PH_PATCH,
		PH_PRE,
		PH_BUILD
	} phase_t;

	// Input register.
	logic       vld_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Parser state.
	phase_t               phase_q;
	logic [NW-1:0]        major_q, minor_q, patch_q;
	logic                 digit_seen_q;
	logic [3:0]           flags_q;
	logic [PW-1:0]        pos_q;
	logic [7:0]           pre_start_q, build_start_q;
	logic                 pre_has_q, build_has_q;
	ssp_pkg::error_kind_t err_q;

	// Next state for the character in the input register.
	phase_t               phase_nxt;
	logic [NW-1:0]        major_nxt, minor_nxt, patch_nxt;
	logic                 digit_seen_nxt;
	logic [3:0]           flags_nxt;
	logic [PW-1:0]        pos_nxt;
	logic [7:0]           pre_start_nxt, build_start_nxt;
	logic                 pre_has_nxt, build_has_nxt;
	ssp_pkg::error_kind_t err_nxt, err_fin;

	logic                 char_num, is_ident;
	logic [NW-1:0]        cur_acc;
	logic [NW+3:0]        acc_ext;
	logic                 acc_ovf;
	logic                 ok;
	logic [7:0]           pos8;
	ssp_pkg::result_t     res_nxt, res_q;

	logic stall_s1, adv_s1;

	// An identifier may not be empty, and a numeric one longer than a digit may
	// not open with a zero.
	function automatic logic part_ok(input logic [3:0] f);
		part_ok = !f[ssp_pkg::PF_EMPTY] &&
			!(f[ssp_pkg::PF_ZERO] && f[ssp_pkg::PF_MULTI] && !f[ssp_pkg::PF_NONDIGIT]);
	endfunction

	// A final character cannot move on while the previous result is still waiting.
	assign stall_s1 = vld_s1 && last_s1 && m_tvalid && !m_tready;
	assign adv_s1   = vld_s1 && !stall_s1;
	assign s_tready = !stall_s1;

	always_comb begin
		char_num = (char_s1 >= ssp_pkg::CH_ZERO) && (char_s1 <= ssp_pkg::CH_NINE);
		is_ident = char_num || (char_s1 == ssp_pkg::CH_MINUS) ||
			((char_s1 >= ssp_pkg::CH_LO_A) && (char_s1 <= ssp_pkg::CH_LO_Z)) ||
			((char_s1 >= ssp_pkg::CH_UP_A) && (char_s1 <= ssp_pkg::CH_UP_Z));

		case (phase_q)
			PH_MAJOR: cur_acc = major_q;
			PH_MINOR: cur_acc = minor_q;
			default:  cur_acc = patch_q;
		endcase
		// acc * 10 + digit, with four guard bits to catch overflow.
		acc_ext = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0} +
			(NW+4)'(char_s1[3:0]);
		acc_ovf = |acc_ext[NW+3:NW];

		phase_nxt       = phase_q;
		major_nxt       = major_q;
		minor_nxt       = minor_q;
		patch_nxt       = patch_q;
		digit_seen_nxt  = digit_seen_q;
		flags_nxt       = flags_q;
		pre_start_nxt   = pre_start_q;
		build_start_nxt = build_start_q;
		pre_has_nxt     = pre_has_q;
		build_has_nxt   = build_has_q;
		err_nxt         = err_q;

		if (err_q == ssp_pkg::ERR_NONE) begin
			if (pos_q >= MAX_POS) begin
				err_nxt = ssp_pkg::ERR_SIZE;
			end else begin
				case (phase_q)
					PH_MAJOR, PH_MINOR, PH_PATCH: begin
						if (char_num) begin
							if (digit_seen_q && (cur_acc == '0)) begin
								err_nxt = ssp_pkg::ERR_CORE;
							end else if (acc_ovf) begin
								err_nxt = ssp_pkg::ERR_SIZE;
							end else begin
								digit_seen_nxt = 1'b1;
								case (phase_q)
									PH_MAJOR: major_nxt = acc_ext[NW-1:0];
									PH_MINOR: minor_nxt = acc_ext[NW-1:0];
									default:  patch_nxt = acc_ext[NW-1:0];
								endcase
							end
						end else if ((phase_q != PH_PATCH) && (char_s1 == ssp_pkg::CH_DOT) &&
								digit_seen_q) begin
							phase_nxt      = (phase_q == PH_MAJOR) ? PH_MINOR : PH_PATCH;
							digit_seen_nxt = 1'b0;
						end else if ((phase_q == PH_PATCH) && digit_seen_q &&
								(char_s1 == ssp_pkg::CH_MINUS)) begin
							phase_nxt     = PH_PRE;
							pre_start_nxt = 8'(pos_q) + 8'd1;
							pre_has_nxt   = 1'b1;
							flags_nxt     = 4'b0001 << ssp_pkg::PF_EMPTY;
						end else if ((phase_q == PH_PATCH) && digit_seen_q &&
								(char_s1 == ssp_pkg::CH_PLUS)) begin
							phase_nxt       = PH_BUILD;
							build_start_nxt = 8'(pos_q) + 8'd1;
							build_has_nxt   = 1'b1;
							flags_nxt       = 4'b0001 << ssp_pkg::PF_EMPTY;
						end else begin
							err_nxt = ssp_pkg::ERR_CORE;
						end
					end
					PH_PRE: begin
						if ((char_s1 == ssp_pkg::CH_DOT) || (char_s1 == ssp_pkg::CH_PLUS)) begin
							if (!part_ok(flags_q)) begin
								err_nxt = ssp_pkg::ERR_PRE;
							end else if (char_s1 == ssp_pkg::CH_DOT) begin
								flags_nxt = 4'b0001 << ssp_pkg::PF_EMPTY;
							end else begin
								phase_nxt       = PH_BUILD;
								build_start_nxt = 8'(pos_q) + 8'd1;
								build_has_nxt   = 1'b1;
								flags_nxt       = 4'b0001 << ssp_pkg::PF_EMPTY;
							end
						end else if (is_ident) begin
							if (flags_q[ssp_pkg::PF_EMPTY]) begin
								flags_nxt = '0;
								flags_nxt[ssp_pkg::PF_ZERO] = (char_s1 == ssp_pkg::CH_ZERO);
							end else begin
								flags_nxt[ssp_pkg::PF_MULTI] = 1'b1;
							end
							if (!char_num) begin
								flags_nxt[ssp_pkg::PF_NONDIGIT] = 1'b1;
							end
						end else begin
							err_nxt = ssp_pkg::ERR_PRE;
						end
					end
					PH_BUILD: begin
						if (char_s1 == ssp_pkg::CH_DOT) begin
							if (flags_q[ssp_pkg::PF_EMPTY]) begin
								err_nxt = ssp_pkg::ERR_BUILD;
							end else begin
								flags_nxt = 4'b0001 << ssp_pkg::PF_EMPTY;
							end
						end else if (is_ident) begin
							flags_nxt = '0;
						end else begin
							err_nxt = ssp_pkg::ERR_BUILD;
						end
					end
					default: begin
						err_nxt = ssp_pkg::ERR_CORE;
					end
				endcase
			end
		end

		pos_nxt = (pos_q <= MAX_POS) ? pos_q + PW'(1) : pos_q;

		// Checks that only apply once the string has ended.
		err_fin = err_nxt;
		if (err_nxt == ssp_pkg::ERR_NONE) begin
			case (phase_nxt)
				PH_MAJOR, PH_MINOR: err_fin = ssp_pkg::ERR_DOT;
				PH_PATCH: begin
					if (!digit_seen_nxt) begin
						err_fin = ssp_pkg::ERR_CORE;
					end
				end
				PH_PRE: begin
					if (!part_ok(flags_nxt)) begin
						err_fin = ssp_pkg::ERR_PRE;
					end
				end
				default: begin
					if (flags_nxt[ssp_pkg::PF_EMPTY]) begin
						err_fin = ssp_pkg::ERR_BUILD;
					end
				end
			endcase
		end

		ok   = (err_fin == ssp_pkg::ERR_NONE);
		pos8 = 8'(pos_nxt);

		res_nxt                    = '0;
		res_nxt.valid_res          = ok;
		res_nxt.error_kind         = err_fin;
		if (ok) begin
			res_nxt.major_value = 32'(major_nxt);
			res_nxt.minor_value = 32'(minor_nxt);
			res_nxt.patch_value = 32'(patch_nxt);
			if (pre_has_nxt) begin
				res_nxt.has_pre_release    = 1'b1;
				res_nxt.pre_release_offset = pre_start_nxt;
				res_nxt.pre_rel_len        = build_has_nxt ?
					(build_start_nxt - 8'd1 - pre_start_nxt) : (pos8 - pre_start_nxt);
			end
			if (build_has_nxt) begin
				res_nxt.has_build    = 1'b1;
				res_nxt.build_offset = build_start_nxt;
				res_nxt.build_len    = pos8 - build_start_nxt;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (adv_s1 && last_s1) begin
			res_q <= res_nxt;
		end
	end

	// Parser state and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			m_tvalid      <= 1'b0;
			phase_q       <= PH_MAJOR;
			major_q       <= '0;
			minor_q       <= '0;
			patch_q       <= '0;
			digit_seen_q  <= 1'b0;
			flags_q       <= 4'b0001 << ssp_pkg::PF_EMPTY;
			pos_q         <= '0;
			pre_start_q   <= '0;
			build_start_q <= '0;
			pre_has_q     <= 1'b0;
			build_has_q   <= 1'b0;
			err_q         <= ssp_pkg::ERR_NONE;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (adv_s1 && last_s1) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (adv_s1) begin
				if (last_s1) begin
					// The string is done: start over for the next one.
					phase_q       <= PH_MAJOR;
					major_q       <= '0;
					minor_q       <= '0;
					patch_q       <= '0;
					digit_seen_q  <= 1'b0;
					flags_q       <= 4'b0001 << ssp_pkg::PF_EMPTY;
					pos_q         <= '0;
					pre_start_q   <= '0;
					build_start_q <= '0;
					pre_has_q     <= 1'b0;
					build_has_q   <= 1'b0;
					err_q         <= ssp_pkg::ERR_NONE;
				end else begin
					phase_q       <= phase_nxt;
					major_q       <= major_nxt;
					minor_q       <= minor_nxt;
					patch_q       <= patch_nxt;
					digit_seen_q  <= digit_seen_nxt;
					flags_q       <= flags_nxt;
					pos_q         <= pos_nxt;
					pre_start_q   <= pre_start_nxt;
					build_start_q <= build_start_nxt;
					pre_has_q     <= pre_has_nxt;
					build_has_q   <= build_has_nxt;
					err_q         <= err_nxt;
				end
			end
		end
	end

	assign m_tdata = {2'b00, res_q};

	// A result is valid exactly when it carries no error kind.
	`SSP_ASSERT_NOW(a_valid_matches_error, m_tvalid,
		m_tdata[0] == (m_tdata[3:1] == ssp_pkg::ERR_NONE), "valid_res disagrees with error_kind")

	// A failed parse reports no numbers and no optional parts.
	`SSP_ASSERT_NOW(a_invalid_is_clear, m_tvalid && !m_tdata[0],
		m_tdata[133:4] == '0, "invalid result carries nonzero fields")

	// A final character stuck behind a waiting result blocks further input.
	`SSP_ASSERT_NOW(a_last_blocks_input, vld_s1 && last_s1 && m_tvalid && !m_tready,
		!s_tready, "input accepted while final character is stalled")

	// Each finished string returns the parser to the start of the major field.
	`SSP_ASSERT_NEXT(a_restart_after_last, adv_s1 && last_s1,
		(phase_q == PH_MAJOR) && (pos_q == '0) && (err_q == ssp_pkg::ERR_NONE) && m_tvalid,
		"parser did not restart after a final character")

endmodule

>>> tb/sv/semver_string_parser_top_test.sv
// Self-checking testbench for the streaming semantic version string parser.
`timescale 1ns / 100ps

module semver_string_parser_top_test;

	// The whole run stays far below this; hitting it means a hang.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 800;
	localparam int MAX_LEN = ssp_pkg::MAX_LENGTH_DEF;
	// Largest value a core number may take before it overflows.
	localparam longint unsigned NUM_LIMIT = (64'd1 << ssp_pkg::NUMBER_WIDTH_DEF) - 64'd1;
	// Identifier flags as they stand right after a separator.
	localparam logic [3:0] FLAGS_FRESH = 4'(1 << ssp_pkg::PF_EMPTY);
	// Directed rows that carry this code are checked against the predictor.
	localparam int USE_PREDICTOR = -1;

	// Which part of the version string the parser is in.
	typedef enum logic [2:0] {
		FLD_MAJOR = 3'd0,
		FLD_MINOR = 3'd1,
		FLD_PATCH = 3'd2,
		FLD_PRE   = 3'd3,
		FLD_BUILD = 3'd4
	} field_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;   // [7:0] character
	logic         s_tlast = 1'b0; // final character of the string
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// From bit 0 up: valid_res, error_kind, major, minor, patch, has_pre_release,
	// pre_release_offset, pre_rel_len, has_build, build_offset, build_len, pad.
	logic [135:0] m_tdata;

	semver_string_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Parse results that the predictor has produced and the block still owes,
	// oldest first.
	ssp_pkg::result_t parse_results_due[$];
	int               mismatch_count = 0;

	// ------------------------------------------------------------------
	// Predictor: its own copy of the parser state, advanced once per accepted
	// character request.
	// ------------------------------------------------------------------
	field_t               psr_field;
	longint unsigned      core_acc [3];
	bit                   digit_seen;
	logic [3:0]           id_flags;
	int                   char_pos;
	int                   pre_at;
	int                   build_at;
	bit                   pre_seen;
	bit                   build_seen;
	ssp_pkg::error_kind_t first_error;

	function automatic void clear_parser();
		psr_field   = FLD_MAJOR;
		core_acc[0] = 0;
		core_acc[1] = 0;
		core_acc[2] = 0;
		digit_seen  = 1'b0;
		id_flags    = FLAGS_FRESH;
		char_pos    = 0;
		pre_at      = 0;
		build_at    = 0;
		pre_seen    = 1'b0;
		build_seen  = 1'b0;
		first_error = ssp_pkg::ERR_NONE;
	endfunction

	// Only the first error of a string is kept.
	function automatic void note_error(input ssp_pkg::error_kind_t kind);
		if (first_error == ssp_pkg::ERR_NONE) begin
			first_error = kind;
		end
	endfunction

	function automatic bit is_numeral(input byte unsigned c);
		return c >= ssp_pkg::CH_ZERO && c <= ssp_pkg::CH_NINE;
	endfunction

	function automatic bit is_ident(input byte unsigned c);
		return is_numeral(c) || c == ssp_pkg::CH_MINUS ||
			(c >= ssp_pkg::CH_LO_A && c <= ssp_pkg::CH_LO_Z) ||
			(c >= ssp_pkg::CH_UP_A && c <= ssp_pkg::CH_UP_Z);
	endfunction

	// A pre-release identifier must be non-empty, and a purely numeric one of
	// more than one digit must not start with zero.
	function automatic bit pre_ident_ok();
		if (id_flags[ssp_pkg::PF_EMPTY]) begin
			return 1'b0;
		end
		return !(id_flags[ssp_pkg::PF_ZERO] && id_flags[ssp_pkg::PF_MULTI] &&
			!id_flags[ssp_pkg::PF_NONDIGIT]);
	endfunction

	// Multiply-by-ten accumulate of the core number being parsed. A digit after
	// a leading zero is an error, as is a value that no longer fits.
	function automatic void core_digit(input longint unsigned d);
		int idx;
		idx = int'(psr_field);
		if (digit_seen && core_acc[idx] == 0) begin
			note_error(ssp_pkg::ERR_CORE);
		end else if (core_acc[idx] > (NUM_LIMIT - d) / 10) begin
			note_error(ssp_pkg::ERR_SIZE);
		end else begin
			core_acc[idx] = core_acc[idx] * 10 + d;
			digit_seen = 1'b1;
		end
	endfunction

	function automatic void enter_build();
		psr_field  = FLD_BUILD;
		build_at   = char_pos + 1;
		build_seen = 1'b1;
		id_flags   = FLAGS_FRESH;
	endfunction

	function automatic void consume(input byte unsigned c);
		case (psr_field)
			FLD_MAJOR, FLD_MINOR: begin
				if (is_numeral(c)) begin
					core_digit(c - ssp_pkg::CH_ZERO);
				end else if (c == ssp_pkg::CH_DOT && digit_seen) begin
					psr_field  = (psr_field == FLD_MAJOR) ? FLD_MINOR : FLD_PATCH;
					digit_seen = 1'b0;
				end else begin
					note_error(ssp_pkg::ERR_CORE);
				end
			end
			FLD_PATCH: begin
				if (is_numeral(c)) begin
					core_digit(c - ssp_pkg::CH_ZERO);
				end else if (c == ssp_pkg::CH_MINUS && digit_seen) begin
					psr_field = FLD_PRE;
					pre_at    = char_pos + 1;
					pre_seen  = 1'b1;
					id_flags  = FLAGS_FRESH;
				end else if (c == ssp_pkg::CH_PLUS && digit_seen) begin
					enter_build();
				end else begin
					// This also catches a third dot inside the patch number.
					note_error(ssp_pkg::ERR_CORE);
				end
			end
			FLD_PRE: begin
				if (c == ssp_pkg::CH_DOT || c == ssp_pkg::CH_PLUS) begin
					if (!pre_ident_ok()) begin
						note_error(ssp_pkg::ERR_PRE);
					end else if (c == ssp_pkg::CH_DOT) begin
						id_flags = FLAGS_FRESH;
					end else begin
						enter_build();
					end
				end else if (is_ident(c)) begin
					if (id_flags[ssp_pkg::PF_EMPTY]) begin
						id_flags = '0;
						id_flags[ssp_pkg::PF_ZERO] = (c == ssp_pkg::CH_ZERO);
					end else begin
						id_flags[ssp_pkg::PF_MULTI] = 1'b1;
					end
					if (!is_numeral(c)) begin
						id_flags[ssp_pkg::PF_NONDIGIT] = 1'b1;
					end
				end else begin
					note_error(ssp_pkg::ERR_PRE);
				end
			end
			FLD_BUILD: begin
				// Inside the build a hyphen is an ordinary character and a plus
				// is an error.
				if (c == ssp_pkg::CH_DOT) begin
					if (id_flags[ssp_pkg::PF_EMPTY]) begin
						note_error(ssp_pkg::ERR_BUILD);
					end else begin
						id_flags = FLAGS_FRESH;
					end
				end else if (is_ident(c)) begin
					id_flags = '0;
				end else begin
					note_error(ssp_pkg::ERR_BUILD);
				end
			end
			default: begin
				note_error(ssp_pkg::ERR_CORE);
			end
		endcase
	endfunction

	// Advances the predictor by one character. On the final character it
	// returns 1 with the full parse result and starts over on a fresh string.
	function automatic bit parse_char(input byte unsigned c, input bit fin,
		output ssp_pkg::result_t res);
		res = '0;
		if (first_error == ssp_pkg::ERR_NONE) begin
			if (char_pos >= MAX_LEN) begin
				note_error(ssp_pkg::ERR_SIZE);
			end else begin
				consume(c);
			end
		end
		if (char_pos <= MAX_LEN) begin
			char_pos++;
		end
		if (!fin) begin
			return 1'b0;
		end
		// Checks that only the end of the string can settle.
		if (first_error == ssp_pkg::ERR_NONE) begin
			case (psr_field)
				FLD_MAJOR, FLD_MINOR: note_error(ssp_pkg::ERR_DOT);
				FLD_PATCH: begin
					if (!digit_seen) begin
						note_error(ssp_pkg::ERR_CORE);
					end
				end
				FLD_PRE: begin
					if (!pre_ident_ok()) begin
						note_error(ssp_pkg::ERR_PRE);
					end
				end
				default: begin
					if (id_flags[ssp_pkg::PF_EMPTY]) begin
						note_error(ssp_pkg::ERR_BUILD);
					end
				end
			endcase
		end
		res.error_kind = first_error;
		// An invalid string reports its error kind and nothing else.
		if (first_error == ssp_pkg::ERR_NONE) begin
			res.valid_res   = 1'b1;
			res.major_value = core_acc[0][31:0];
			res.minor_value = core_acc[1][31:0];
			res.patch_value = core_acc[2][31:0];
			if (pre_seen) begin
				res.has_pre_release    = 1'b1;
				res.pre_release_offset = 8'(pre_at);
				res.pre_rel_len = 8'(build_seen ? build_at - 1 - pre_at : char_pos - pre_at);
			end
			if (build_seen) begin
				res.has_build    = 1'b1;
				res.build_offset = 8'(build_at);
				res.build_len    = 8'(char_pos - build_at);
			end
		end
		clear_parser();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Character source.
	// ------------------------------------------------------------------

	// Sends one string, one character request at a time. Entered and left at a
	// falling edge. Each request is preceded by a random gap, except in calm
	// strings that stream back to back. A typed expectation replaces the
	// predicted result, though the predictor still follows every character.
	task automatic send_version(input byte unsigned chars[$], input bit typed,
		input ssp_pkg::result_t want);
		int               gap;
		bit               calm;
		bit               done;
		ssp_pkg::result_t predicted;
		calm = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < chars.size(); i++) begin
			gap = calm ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_tvalid = 1'b1;
			s_tdata  = chars[i];
			s_tlast  = (i == chars.size() - 1);
			do @(posedge clk); while (!s_tready);
			done = parse_char(chars[i], i == chars.size() - 1, predicted);
			if (done) begin
				parse_results_due.push_back(typed ? want : predicted);
			end
			@(negedge clk);
		end
	endtask

	// Holds the source idle until the block has delivered every result it owes.
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (parse_results_due.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	function automatic void push_text(ref byte unsigned q[$], input string s);
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
	endfunction

	// Core numbers: mostly plain values, with the full 32-bit range, the
	// largest legal value, leading zeros and overflow now and then.
	function automatic string rand_number();
		int k;
		k = $urandom_range(0, 31);
		if (k < 6) begin
			return "0";
		end else if (k < 20) begin
			return $sformatf("%0d", $urandom_range(1, 999));
		end else if (k < 27) begin
			return $sformatf("%0d", $urandom);
		end else if (k == 27) begin
			return $sformatf("0%0d", $urandom_range(0, 99));
		end else if (k < 30) begin
			return "4294967295";
		end
		return $sformatf("%0d", 64'd4294967296 + longint'($urandom_range(0, 99999)));
	endfunction

	function automatic byte unsigned ident_char();
		case ($urandom_range(0, 6))
			0, 1: return ssp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
			2, 3: return ssp_pkg::CH_LO_A + 8'($urandom_range(0, 25));
			4, 5: return ssp_pkg::CH_UP_A + 8'($urandom_range(0, 25));
			default: return ssp_pkg::CH_MINUS;
		endcase
	endfunction

	// One identifier; a third of them are purely numeric, which sometimes
	// gives a forbidden leading zero.
	function automatic void push_ident(ref byte unsigned q[$]);
		int n;
		bit numeric;
		n = $urandom_range(1, 5);
		numeric = ($urandom_range(0, 2) == 0);
		repeat (n) begin
			q.push_back(numeric ? ssp_pkg::CH_ZERO + 8'($urandom_range(0, 9)) : ident_char());
		end
	endfunction

	// A well-formed version with random content, broken now and then by
	// replacing, dropping or inserting a single character.
	function automatic void gen_version(ref byte unsigned q[$]);
		int n;
		int idx;
		byte unsigned specials [4];
		specials = '{ssp_pkg::CH_DOT, ssp_pkg::CH_MINUS, ssp_pkg::CH_PLUS, ssp_pkg::CH_ZERO};
		push_text(q, rand_number());
		q.push_back(ssp_pkg::CH_DOT);
		push_text(q, rand_number());
		q.push_back(ssp_pkg::CH_DOT);
		push_text(q, rand_number());
		if ($urandom_range(0, 1) == 1) begin
			q.push_back(ssp_pkg::CH_MINUS);
			n = $urandom_range(1, 3);
			for (int j = 0; j < n; j++) begin
				if (j > 0) begin
					q.push_back(ssp_pkg::CH_DOT);
				end
				push_ident(q);
			end
		end
		if ($urandom_range(0, 2) == 0) begin
			q.push_back(ssp_pkg::CH_PLUS);
			n = $urandom_range(1, 3);
			for (int j = 0; j < n; j++) begin
				if (j > 0) begin
					q.push_back(ssp_pkg::CH_DOT);
				end
				push_ident(q);
			end
		end
		idx = $urandom_range(0, q.size() - 1);
		case ($urandom_range(0, 9))
			0: q[idx] = 8'($urandom_range(0, 255));
			1: q.delete(idx);
			2: q.insert(idx, specials[$urandom_range(0, 3)]);
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result sink and checker.
	// ------------------------------------------------------------------
	int               rx_hold = 0;
	bit               rx_calm = 1'b0;
	ssp_pkg::result_t mon_got;
	ssp_pkg::result_t mon_want;

	// Ready is dropped for a random hold after a result, unless the sink is calm, so
	// stalls also fall on strings that are still being parsed.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic void check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mon_got = ssp_pkg::result_t'(m_tdata[133:0]);
			if (parse_results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				mon_want = parse_results_due.pop_front();
				check_field("valid_res", mon_want.valid_res, mon_got.valid_res);
				check_field("error_kind", mon_want.error_kind, mon_got.error_kind);
				check_field("major_value", mon_want.major_value, mon_got.major_value);
				check_field("minor_value", mon_want.minor_value, mon_got.minor_value);
				check_field("patch_value", mon_want.patch_value, mon_got.patch_value);
				check_field("has_pre_release", mon_want.has_pre_release,
					mon_got.has_pre_release);
				check_field("pre_release_offset", mon_want.pre_release_offset,
					mon_got.pre_release_offset);
				check_field("pre_rel_len", mon_want.pre_rel_len, mon_got.pre_rel_len);
				check_field("has_build", mon_want.has_build, mon_got.has_build);
				check_field("build_offset", mon_want.build_offset, mon_got.build_offset);
				check_field("build_len", mon_want.build_len, mon_got.build_len);
			end
			if ($urandom_range(0, 9) == 0) begin
				rx_calm = !rx_calm;
			end
			rx_hold = rx_calm ? 0 : $urandom_range(0, 17);
		end
	end

	// ------------------------------------------------------------------
	// Directed strings. Rows whose error code is given expect that error with
	// every other field zero; the rest are checked against the predictor.
	// ------------------------------------------------------------------
	string dir_text [28] = '{
		"0.0.0",
		"1.2.3",
		"4294967295.4294967295.4294967295",
		"4294967296.0.0",
		"01.2.3",
		"1.02.3",
		".1.2",
		"1..2",
		"1.2.3.4",
		"1.2.3x",
		"1.2.",
		"1.2",
		"7",
		"01.2",
		"0.0.0-",
		"1.0.0-alpha.1",
		"1.0.0-0.0a.00x-",
		"1.0.0-01",
		"1.0.0-a..b",
		"1.2.3-a.",
		"1.0.0-a$",
		"1.0.0-x-y+Z-9.01",
		"1.0.0+",
		"1.0.0+a+b",
		"1.2.3+a.",
		"1.0.0-rc.1+b..c",
		"1.0.0-A+",
		"10.20.30+a.b-c"
	};
	int dir_err [28] = '{
		USE_PREDICTOR,
		USE_PREDICTOR,
		USE_PREDICTOR,       // largest legal numbers
		ssp_pkg::ERR_SIZE,   // major one past the 32-bit range
		ssp_pkg::ERR_CORE,   // leading zero in major
		ssp_pkg::ERR_CORE,   // leading zero in minor
		ssp_pkg::ERR_CORE,   // empty major
		ssp_pkg::ERR_CORE,   // empty minor
		ssp_pkg::ERR_CORE,   // third dot inside patch
		ssp_pkg::ERR_CORE,   // stray letter in patch
		ssp_pkg::ERR_CORE,   // string ends on an empty patch
		ssp_pkg::ERR_DOT,    // string ends in minor
		ssp_pkg::ERR_DOT,    // string ends in major
		ssp_pkg::ERR_CORE,   // first error wins over the missing dot
		ssp_pkg::ERR_PRE,    // empty pre-release
		USE_PREDICTOR,
		USE_PREDICTOR,       // lone zero and zero-led mixed identifiers are fine
		ssp_pkg::ERR_PRE,    // numeric identifier with a leading zero
		ssp_pkg::ERR_PRE,    // empty identifier between dots
		ssp_pkg::ERR_PRE,    // trailing empty identifier
		ssp_pkg::ERR_PRE,    // illegal pre-release character
		USE_PREDICTOR,       // hyphens inside both parts, zero-led build identifier
		ssp_pkg::ERR_BUILD,  // empty build
		ssp_pkg::ERR_BUILD,  // plus inside the build
		ssp_pkg::ERR_BUILD,  // trailing empty build identifier
		ssp_pkg::ERR_BUILD,  // empty build identifier between dots
		ssp_pkg::ERR_BUILD,  // build opened and left empty
		USE_PREDICTOR
	};

	// Watchdog: a run that goes on this long is stuck.
	int cycle_count = 0;
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		byte unsigned     chars[$];
		ssp_pkg::result_t want;
		int               target;
		int               items_sent;
		int               strings_sent;
		clear_parser();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_text[i]) begin
			chars.delete();
			push_text(chars, dir_text[i]);
			want = '0;
			if (dir_err[i] != USE_PREDICTOR) begin
				want.error_kind = ssp_pkg::error_kind_t'(dir_err[i]);
			end
			send_version(chars, dir_err[i] != USE_PREDICTOR, want);
		end

		// Longest legal string, then one character too many.
		chars.delete();
		push_text(chars, "1.2.3+");
		repeat (MAX_LEN - 6) chars.push_back(ssp_pkg::CH_LO_A);
		send_version(chars, 1'b0, want);
		chars.push_back(ssp_pkg::CH_LO_A);
		want = '0;
		want.error_kind = ssp_pkg::ERR_SIZE;
		send_version(chars, 1'b1, want);

		// Let the block run dry before the random part starts.
		drain_results();

		// Random part: mostly well-formed versions, some broken, some noise,
		// and now and then a string around the length limit.
		items_sent = 0;
		strings_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			chars.delete();
			case ($urandom_range(0, 39))
				0, 1, 2: begin
					repeat ($urandom_range(1, 12)) chars.push_back(8'($urandom_range(0, 255)));
				end
				3: begin
					push_text(chars, "0.0.");
					push_text(chars, rand_number());
					chars.push_back(ssp_pkg::CH_MINUS);
					target = $urandom_range(MAX_LEN - 16, MAX_LEN + 14);
					while (chars.size() < target) begin
						chars.push_back(ident_char());
					end
				end
				default: gen_version(chars);
			endcase
			send_version(chars, 1'b0, want);
			items_sent += chars.size();
			strings_sent++;
			if (strings_sent % 16 == 0) begin
				drain_results();
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/ssp_pkg.sv
rtl/semver_string_parser_top.sv
tb/sv/semver_string_parser_top_test.sv
